[src/query_string_pair_parser_assert.svh]
// Assertion macros for the query string pair parser checker.
// Depends on nothing; included by the checker file.
`ifndef QUERY_STRING_PAIR_PARSER_ASSERT_SVH
`define QUERY_STRING_PAIR_PARSER_ASSERT_SVH

// Implication checked in the same cycle, masked during reset.
`define QSP_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: label");

// Implication checked in the cycle after, masked during reset.
`define QSP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: label");

// Implication checked in the cycle after, active through reset as well.
`define QSP_ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
      else $error("assertion failed: label");

`endif

[src/qsp_pkg.sv]
// Shared types and constants of the query string pair parser.
// Used by the front, back, top level and checker; no dependencies.
`timescale 1ns / 1ps

package qsp_pkg;

   localparam int TOK_DEPTH = 2;
   localparam int TOK_PTR_W = $clog2(TOK_DEPTH);
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3d;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] MAX_PAIRS_RESET = 8'd16;

   typedef enum logic [1:0] {
      KIND_KEY      = 2'd0,
      KIND_VALUE    = 2'd1,
      KIND_PAIR_END = 2'd2,
      KIND_DONE     = 2'd3
   } out_kind_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_byte;
   } req_type;

   typedef struct packed {
      out_kind_type out_kind;
      logic [7:0]   out_byte;
      logic [7:0]   pair_index;
      logic [7:0]   value_length;
      logic         has_value;
      logic         bad_escape;
      logic         string_done;
   } rsp_type;

   // Classified byte handed from front to back.
   typedef struct packed {
      logic       end_str;
      logic       is_amp;
      logic       is_pct;
      logic       is_eq;
      logic       hex_ok;
      logic [3:0] nibble;
      logic [7:0] char_byte;
   } token_type;

endpackage

[src/qsp_front.sv]
// Front end: takes request beats, classifies each byte and queues the token.
// Depends on qsp_pkg.
`timescale 1ns / 1ps

module qsp_front import qsp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_push,
   output logic      req_full,
   input  req_type   req_data,
   input  logic      tok_pop,
   output logic      tok_valid,
   output token_type tok_data
);

   token_type              tok_mem_ff [TOK_DEPTH];
   logic [TOK_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [TOK_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [TOK_PTR_W:0]     count_ff, count_in;
   logic                   push_fire;
   logic                   pop_fire;
   token_type              tok_new;

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   always_comb begin
      tok_new.end_str   = req_data.kind || (req_data.char_byte == 8'h00);
      tok_new.is_amp    = (req_data.char_byte == CHAR_AMP);
      tok_new.is_pct    = (req_data.char_byte == CHAR_PERCENT);
      tok_new.is_eq     = (req_data.char_byte == CHAR_EQUALS);
      {tok_new.hex_ok, tok_new.nibble} = hex_decode(req_data.char_byte);
      tok_new.char_byte = req_data.char_byte;
   end

   assign req_full  = (count_ff == (TOK_PTR_W+1)'(TOK_DEPTH));
   assign tok_valid = (count_ff != '0);
   assign tok_data  = tok_mem_ff[rd_ptr_ff];
   assign push_fire = req_push && !req_full;
   assign pop_fire  = tok_pop && tok_valid;

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (TOK_PTR_W+1)'(push_fire) - (TOK_PTR_W+1)'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         tok_mem_ff[wr_ptr_ff] <= tok_new;
      end
   end

endmodule

[src/qsp_back.sv]
// Back end: pair parser state machine, limit register and result queue.
// Depends on qsp_pkg; fed tokens by qsp_front.
`timescale 1ns / 1ps

module qsp_back import qsp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_write,
   input  logic [7:0] csr_data,
   input  logic      tok_valid,
   output logic      tok_pop,
   input  token_type tok_data,
   output logic      rsp_empty,
   input  logic      rsp_pop,
   output rsp_type   rsp_data
);

   typedef enum logic [4:0] {
      PH_KEY   = 5'b00001,
      PH_VALUE = 5'b00010,
      PH_ESC1  = 5'b00100,
      PH_ESC2  = 5'b01000,
      PH_SKIP  = 5'b10000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] high_nibble_ff, high_nibble_in;
   logic [7:0] pair_count_ff, pair_count_in;
   logic [7:0] value_count_ff, value_count_in;
   logic       seen_equals_ff, seen_equals_in;
   logic       escape_failed_ff, escape_failed_in;
   logic [7:0] max_pairs_ff, max_pairs_in;

   rsp_type              rsp_mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W:0]   count_ff, count_in;

   logic    step;
   logic    emit;
   logic    limited;
   logic    rsp_pop_fire;
   logic    rsp_can_push;
   rsp_type res;
   rsp_type pair_end;

   assign rsp_empty    = (count_ff == '0);
   assign rsp_data     = rsp_mem_ff[rd_ptr_ff];
   assign rsp_pop_fire = rsp_pop && !rsp_empty;
   // room is freed by a pop in the same cycle
   assign rsp_can_push = (count_ff != (RSP_PTR_W+1)'(RSP_DEPTH)) || rsp_pop_fire;
   assign step         = tok_valid && rsp_can_push;
   assign tok_pop      = step;
   assign limited      = (pair_count_ff >= max_pairs_ff);

   always_comb begin
      pair_end.out_kind     = KIND_PAIR_END;
      pair_end.out_byte     = 8'h00;
      pair_end.pair_index   = pair_count_ff;
      pair_end.value_length = value_count_ff;
      pair_end.has_value    = seen_equals_ff;
      pair_end.bad_escape   = escape_failed_ff || (phase_ff == PH_ESC1)
                              || (phase_ff == PH_ESC2);
      pair_end.string_done  = 1'b0;
   end

   always_comb begin
      emit             = 1'b0;
      res              = '0;
      res.pair_index   = pair_count_ff;
      phase_in         = phase_ff;
      high_nibble_in   = high_nibble_ff;
      pair_count_in    = pair_count_ff;
      value_count_in   = value_count_ff;
      seen_equals_in   = seen_equals_ff;
      escape_failed_in = escape_failed_ff;
      max_pairs_in     = csr_write ? csr_data : max_pairs_ff;

      if (tok_data.end_str || (!limited && tok_data.is_amp)) begin
         emit = 1'b1;
         if (tok_data.end_str && limited) begin
            res.out_kind    = KIND_DONE;
            res.string_done = 1'b1;
         end else begin
            res             = pair_end;
            res.string_done = tok_data.end_str;
         end
         // end of string restarts the count, a separator advances it
         pair_count_in    = tok_data.end_str ? 8'h00 : pair_count_ff + 8'd1;
         phase_in         = PH_KEY;
         high_nibble_in   = 4'h0;
         value_count_in   = 8'h00;
         seen_equals_in   = 1'b0;
         escape_failed_in = 1'b0;
      end else if (!limited) begin
         case (phase_ff)
            PH_VALUE: begin
               if (tok_data.is_pct) begin
                  phase_in = PH_ESC1;
               end else begin
                  emit           = 1'b1;
                  res.out_kind   = KIND_VALUE;
                  res.out_byte   = tok_data.char_byte;
                  value_count_in = value_count_ff + 8'd1;
               end
            end
            PH_ESC1: begin
               if (tok_data.hex_ok) begin
                  high_nibble_in = tok_data.nibble;
                  phase_in       = PH_ESC2;
               end else begin
                  escape_failed_in = 1'b1;
                  phase_in         = PH_SKIP;
               end
            end
            PH_ESC2: begin
               if (tok_data.hex_ok) begin
                  emit           = 1'b1;
                  res.out_kind   = KIND_VALUE;
                  res.out_byte   = {high_nibble_ff, tok_data.nibble};
                  value_count_in = value_count_ff + 8'd1;
                  phase_in       = PH_VALUE;
               end else begin
                  escape_failed_in = 1'b1;
                  phase_in         = PH_SKIP;
               end
            end
            PH_SKIP: begin
               // drop the rest of the value
            end
            default: begin
               if (tok_data.is_eq) begin
                  seen_equals_in = 1'b1;
                  phase_in       = PH_VALUE;
               end else begin
                  emit         = 1'b1;
                  res.out_kind = KIND_KEY;
                  res.out_byte = tok_data.char_byte;
               end
            end
         endcase
      end
   end

   always_comb begin
      wr_ptr_in = (step && emit) ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rsp_pop_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (RSP_PTR_W+1)'(step && emit)
                  - (RSP_PTR_W+1)'(rsp_pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_KEY;
         high_nibble_ff   <= 4'h0;
         pair_count_ff    <= 8'h00;
         value_count_ff   <= 8'h00;
         seen_equals_ff   <= 1'b0;
         escape_failed_ff <= 1'b0;
         max_pairs_ff     <= MAX_PAIRS_RESET;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         max_pairs_ff <= max_pairs_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         if (step) begin
            phase_ff         <= phase_in;
            high_nibble_ff   <= high_nibble_in;
            pair_count_ff    <= pair_count_in;
            value_count_ff   <= value_count_in;
            seen_equals_ff   <= seen_equals_in;
            escape_failed_ff <= escape_failed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_mem_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

[src/query_string_pair_parser.sv]
// Query string pair parser: one query string byte per beat in, key bytes,
// decoded value bytes and pair ends out. Throughput is one byte per cycle
// while the result queue has room, set by the back-end parser's state update.
// A byte is registered in the token queue, and its result, if any, is then
// registered in the result queue that drives the rsp ports. Synchronous reset
// empties both queues, clears the parser and sets max_pairs to 16.
`timescale 1ns / 1ps

module query_string_pair_parser import qsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic      tok_valid;
   logic      tok_pop;
   token_type tok_data;

   assign csr_ready = 1'b1;

   qsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .tok_pop   (tok_pop),
      .tok_valid (tok_valid),
      .tok_data  (tok_data)
   );

   qsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .tok_valid (tok_valid),
      .tok_pop   (tok_pop),
      .tok_data  (tok_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[src/qsp_checker.sv]
// Port-level checks of the query string pair parser, bound to the top level.
// Depends on qsp_pkg and query_string_pair_parser_assert.svh.
`timescale 1ns / 1ps
`include "query_string_pair_parser_assert.svh"

module qsp_checker import qsp_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input rsp_type    rsp_data
);

   logic rsp_wait;
   logic rsp_done;
   logic rsp_byte;
   logic done_ok;
   logic byte_ok;

   assign rsp_wait = !rsp_empty && !rsp_pop;
   assign rsp_done = !rsp_empty && (rsp_data.out_kind == KIND_DONE);
   assign rsp_byte = !rsp_empty && (rsp_data.out_kind == KIND_KEY
                                    || rsp_data.out_kind == KIND_VALUE);
   assign done_ok  = rsp_data.string_done && !rsp_data.has_value
                     && !rsp_data.bad_escape && (rsp_data.value_length == 8'h00);
   assign byte_ok  = !rsp_data.string_done && !rsp_data.has_value
                     && !rsp_data.bad_escape && (rsp_data.value_length == 8'h00);

   `QSP_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, rsp_empty && !req_full)
   `QSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, !rsp_empty && $stable(rsp_data))
   `QSP_ASSERT_IMPLY(a_done_fields, clock, reset, rsp_done, done_ok)
   `QSP_ASSERT_IMPLY(a_byte_fields, clock, reset, rsp_byte, byte_ok)

endmodule

bind query_string_pair_parser qsp_checker u_checker (.*);
